@@ sv/wide_register_instruction_unit_core_macros.svh @@
// Assertion macros for the wide register instruction unit.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef WIDE_REGISTER_INSTRUCTION_UNIT_CORE_MACROS_SVH
`define WIDE_REGISTER_INSTRUCTION_UNIT_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define WRUI_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define WRUI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/wrui_pkg.sv @@
// Shared types and constants of the wide register instruction unit.
// No dependencies; used by every module of the block.
package wrui_pkg;

	localparam int QueueDepth = 2;

	localparam int OpcodeW   = 8;
	localparam int WordW     = 16;
	localparam int InDataW   = 40;
	localparam int OutDataW  = 64;

	// Opcode groups and single opcodes
	localparam logic [7:0] OP_ST_SP     = 8'h08;
	localparam logic [7:0] OP_LD_SP_HL  = 8'hF9;
	localparam logic [7:0] OP_ADD_SP    = 8'hE8;
	localparam logic [7:0] OP_LD_HL_SPE = 8'hF8;

	// Low nibble of the opcode inside the 00..3F group
	localparam logic [3:0] LO_LD_IMM = 4'h1;
	localparam logic [3:0] LO_INC    = 4'h3;
	localparam logic [3:0] LO_DEC    = 4'hB;
	localparam logic [3:0] LO_ADD_HL = 4'h9;
	// Low nibble of the opcode inside the C0..FF group
	localparam logic [3:0] LO_POP    = 4'h1;
	localparam logic [3:0] LO_PUSH   = 4'h5;

	// Register pair selectors (bits 5:4 of the opcode)
	localparam logic [1:0] PAIR_BC    = 2'd0;
	localparam logic [1:0] PAIR_DE    = 2'd1;
	localparam logic [1:0] PAIR_HL    = 2'd2;
	localparam logic [1:0] PAIR_SP_AF = 2'd3;

	// Idle bus cycle counts
	localparam logic [1:0] IDLE_NONE = 2'd0;
	localparam logic [1:0] IDLE_ONE  = 2'd1;
	localparam logic [1:0] IDLE_TWO  = 2'd2;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	typedef enum logic [3:0] {
		KIND_LD_IMM,
		KIND_INC,
		KIND_DEC,
		KIND_ADD_HL,
		KIND_POP,
		KIND_PUSH,
		KIND_ST_SP,
		KIND_LD_SP_HL,
		KIND_ADD_SP,
		KIND_LD_HL_SPE,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  pair;
		logic [15:0] immediate;
		logic [15:0] stack_word;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

@@ sv/wrui_front.sv @@
// Front end: input handshake and opcode classification.
// Depends on wrui_pkg; feeds the decoded item into wrui_queue.
module wrui_front (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wrui_pkg::InDataW-1:0]  s_tdata,   // opcode, immediate, stack_word
	input  logic                          queue_full,
	output logic                          push,
	output wrui_pkg::item_t               item
);

	logic [7:0] opcode;
	logic [3:0] lo;

	assign opcode   = s_tdata[7:0];
	assign lo       = opcode[3:0];
	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	always_comb begin
		item.kind       = wrui_pkg::KIND_BAD;
		item.pair       = opcode[5:4];
		item.immediate  = s_tdata[23:8];
		item.stack_word = s_tdata[39:24];
		if (opcode inside {[8'h00:8'h3F]}) begin
			case (lo)
				wrui_pkg::LO_LD_IMM: item.kind = wrui_pkg::KIND_LD_IMM;
				wrui_pkg::LO_INC:    item.kind = wrui_pkg::KIND_INC;
				wrui_pkg::LO_DEC:    item.kind = wrui_pkg::KIND_DEC;
				wrui_pkg::LO_ADD_HL: item.kind = wrui_pkg::KIND_ADD_HL;
				default:             item.kind = wrui_pkg::KIND_BAD;
			endcase
		end else if (opcode inside {[8'hC0:8'hFF]}) begin
			case (lo)
				wrui_pkg::LO_POP:  item.kind = wrui_pkg::KIND_POP;
				wrui_pkg::LO_PUSH: item.kind = wrui_pkg::KIND_PUSH;
				default:           item.kind = wrui_pkg::KIND_BAD;
			endcase
		end
		// Single opcodes never collide with the group patterns above
		case (opcode)
			wrui_pkg::OP_ST_SP:     item.kind = wrui_pkg::KIND_ST_SP;
			wrui_pkg::OP_LD_SP_HL:  item.kind = wrui_pkg::KIND_LD_SP_HL;
			wrui_pkg::OP_ADD_SP:    item.kind = wrui_pkg::KIND_ADD_SP;
			wrui_pkg::OP_LD_HL_SPE: item.kind = wrui_pkg::KIND_LD_HL_SPE;
			default: ;
		endcase
	end

endmodule

@@ sv/wrui_queue.sv @@
// Short register queue between front and back end.
// Depends on wrui_pkg for the item type.
module wrui_queue #(
	parameter int QUEUE_DEPTH = wrui_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  wrui_pkg::item_t  item,
	output logic             full,
	input  logic             pop,
	output wrui_pkg::head_t  head
);

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	wrui_pkg::item_t entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/wrui_back.sv @@
// Back end: register file, execution and registered result stage.
// Depends on wrui_pkg; takes items from the head of wrui_queue.
module wrui_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  wrui_pkg::head_t                head,
	output logic                           pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wrui_pkg::OutDataW-1:0]  m_tdata,  // status, write_valid, write_address,
	                                                 // write_data, internal_cycles,
	                                                 // flag_bits, hl_value, sp_value
	output logic                           m_tlast
);

	// Architectural state
	logic [15:0] bc_q, de_q, hl_q, sp_q;
	logic [7:0]  a_q;
	logic [3:0]  f_q;
	logic        phase_q;

	// Next state
	logic [15:0] bc_d, de_d, hl_d, sp_d;
	logic [7:0]  a_d;
	logic [3:0]  f_d;

	// Result stage
	logic        out_valid_q;
	logic        out_status_q, out_wv_q, out_last_q;
	logic [15:0] out_addr_q, out_hl_q, out_sp_q;
	logic [7:0]  out_data_q;
	logic [1:0]  out_idle_q;
	logic [3:0]  out_flags_q;

	logic        res_status, res_wv, res_last;
	logic [15:0] res_addr;
	logic [7:0]  res_data;
	logic [1:0]  res_idle;

	logic        load, fire, two_beat, update;
	logic [15:0] rp, push_word, sp_offset;
	logic [16:0] sum17;
	logic [12:0] sum13;
	logic [8:0]  sum9;
	logic [4:0]  sum5;
	logic [7:0]  e;
	wrui_pkg::item_t it;

	assign it       = head.item;
	assign load     = !out_valid_q || m_tready;
	assign fire     = load && head.valid;
	assign two_beat = (it.kind == wrui_pkg::KIND_PUSH) || (it.kind == wrui_pkg::KIND_ST_SP);
	assign pop      = fire && (!two_beat || phase_q);
	assign update   = fire && !phase_q;

	assign e         = it.immediate[7:0];
	assign sum17     = {1'b0, hl_q} + {1'b0, rp};
	assign sum13     = {1'b0, hl_q[11:0]} + {1'b0, rp[11:0]};
	assign sum9      = {1'b0, sp_q[7:0]} + {1'b0, e};
	assign sum5      = {1'b0, sp_q[3:0]} + {1'b0, e[3:0]};
	assign sp_offset = sp_q + {{8{e[7]}}, e};
	assign push_word = (it.pair == wrui_pkg::PAIR_SP_AF) ? {a_q, f_q, 4'h0} : rp;

	always_comb begin
		case (it.pair)
			wrui_pkg::PAIR_BC: rp = bc_q;
			wrui_pkg::PAIR_DE: rp = de_q;
			wrui_pkg::PAIR_HL: rp = hl_q;
			default:           rp = sp_q;
		endcase
	end

	always_comb begin
		bc_d = bc_q;
		de_d = de_q;
		hl_d = hl_q;
		sp_d = sp_q;
		a_d  = a_q;
		f_d  = f_q;
		res_status = wrui_pkg::STATUS_DONE;
		res_wv     = 1'b0;
		res_addr   = '0;
		res_data   = '0;
		res_idle   = wrui_pkg::IDLE_NONE;
		res_last   = 1'b1;
		case (it.kind)
			wrui_pkg::KIND_LD_IMM, wrui_pkg::KIND_INC, wrui_pkg::KIND_DEC: begin
				logic [15:0] v;
				v = it.immediate;
				if (it.kind == wrui_pkg::KIND_INC) v = rp + 16'd1;
				if (it.kind == wrui_pkg::KIND_DEC) v = rp - 16'd1;
				if (it.kind != wrui_pkg::KIND_LD_IMM) res_idle = wrui_pkg::IDLE_ONE;
				case (it.pair)
					wrui_pkg::PAIR_BC: bc_d = v;
					wrui_pkg::PAIR_DE: de_d = v;
					wrui_pkg::PAIR_HL: hl_d = v;
					default:           sp_d = v;
				endcase
			end
			wrui_pkg::KIND_ADD_HL: begin
				hl_d     = sum17[15:0];
				f_d      = {f_q[3], 1'b0, sum13[12], sum17[16]};
				res_idle = wrui_pkg::IDLE_ONE;
			end
			wrui_pkg::KIND_POP: begin
				// Pair code 3 means AF here; flags take bits 7..4 of the low byte
				case (it.pair)
					wrui_pkg::PAIR_BC: bc_d = it.stack_word;
					wrui_pkg::PAIR_DE: de_d = it.stack_word;
					wrui_pkg::PAIR_HL: hl_d = it.stack_word;
					default: begin
						a_d = it.stack_word[15:8];
						f_d = it.stack_word[7:4];
					end
				endcase
				sp_d = sp_q + 16'd2;
			end
			wrui_pkg::KIND_PUSH: begin
				res_wv = 1'b1;
				if (!phase_q) begin
					// High byte first at SP-1; SP drops by two on this beat
					sp_d     = sp_q - 16'd2;
					res_addr = sp_q - 16'd1;
					res_data = push_word[15:8];
					res_last = 1'b0;
				end else begin
					res_addr = sp_q;
					res_data = push_word[7:0];
					res_idle = wrui_pkg::IDLE_ONE;
				end
			end
			wrui_pkg::KIND_ST_SP: begin
				res_wv = 1'b1;
				if (!phase_q) begin
					res_addr = it.immediate;
					res_data = sp_q[7:0];
					res_last = 1'b0;
				end else begin
					res_addr = it.immediate + 16'd1;
					res_data = sp_q[15:8];
				end
			end
			wrui_pkg::KIND_LD_SP_HL: begin
				sp_d     = hl_q;
				res_idle = wrui_pkg::IDLE_ONE;
			end
			wrui_pkg::KIND_ADD_SP: begin
				sp_d     = sp_offset;
				f_d      = {2'b00, sum5[4], sum9[8]};
				res_idle = wrui_pkg::IDLE_TWO;
			end
			wrui_pkg::KIND_LD_HL_SPE: begin
				hl_d     = sp_offset;
				f_d      = {2'b00, sum5[4], sum9[8]};
				res_idle = wrui_pkg::IDLE_ONE;
			end
			default: begin
				res_status = wrui_pkg::STATUS_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= '0;
			de_q        <= '0;
			hl_q        <= '0;
			sp_q        <= '0;
			a_q         <= '0;
			f_q         <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (update) begin
				bc_q <= bc_d;
				de_q <= de_d;
				hl_q <= hl_d;
				sp_q <= sp_d;
				a_q  <= a_d;
				f_q  <= f_d;
			end
			if (fire && two_beat) begin
				phase_q <= !phase_q;
			end
			if (load) begin
				out_valid_q <= head.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= res_status;
			out_wv_q     <= res_wv;
			out_addr_q   <= res_addr;
			out_data_q   <= res_data;
			out_idle_q   <= res_idle;
			out_flags_q  <= update ? f_d : f_q;
			out_hl_q     <= update ? hl_d : hl_q;
			out_sp_q     <= update ? sp_d : sp_q;
			out_last_q   <= res_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_sp_q, out_hl_q, out_flags_q, out_idle_q,
	                   out_data_q, out_addr_q, out_wv_q, out_status_q};

endmodule

@@ sv/wide_register_instruction_unit_core.sv @@
// A result passes the queue register and then the back-end result register before it shows on m_tvalid.
// Throughput: one instruction per cycle while m_tready does not stall the result register; PUSH and
// LD (nn),SP give one result per memory byte, paced by the single result register of the back end.
// Reset (arst_n low): BC, DE, HL, SP, A and flags clear to zero, queue empties,
// no result is pending.
module wide_register_instruction_unit_core #(
	parameter int QUEUE_DEPTH = wrui_pkg::QueueDepth
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wrui_pkg::InDataW-1:0]   s_tdata,   // opcode[7:0], immediate[23:8],
	                                                  // stack_word[39:24]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wrui_pkg::OutDataW-1:0]  m_tdata,   // status[0], write_valid[1],
	                                                  // write_address[17:2],
	                                                  // write_data[25:18],
	                                                  // internal_cycles[27:26],
	                                                  // flag_bits[31:28], hl_value[47:32],
	                                                  // sp_value[63:48]
	output logic                           m_tlast    // last result of the instruction
);

	`include "wide_register_instruction_unit_core_macros.svh"

	// Front to queue: a decoded item and its push strobe
	wrui_pkg::item_t item;
	logic            push;
	logic            queue_full;

	// Queue to back: the head entry and its pop strobe
	wrui_pkg::head_t head;
	logic            pop;

	// Result fields picked out for the checks below
	logic            out_bad;
	logic            out_write;
	logic            out_no_idle;
	logic            first_xfer;

	// Classify opcodes and take a transfer whenever the queue has room
	wrui_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (queue_full),
		.push       (push),
		.item       (item)
	);

	// Hold decoded items so the front keeps taking transfers while results stall
	wrui_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (queue_full),
		.pop    (pop),
		.head   (head)
	);

	// Execute in order against the register file; two-byte writes hold the
	// head entry for a second beat before it is dropped from the queue
	wrui_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	assign out_bad     = m_tdata[0];
	assign out_write   = m_tdata[1];
	assign out_no_idle = (m_tdata[27:26] == wrui_pkg::IDLE_NONE);
	assign first_xfer  = m_tvalid && m_tready && !m_tlast;

	// A not-handled opcode is a single result with no memory write
	`WRUI_ASSERT_SAME(a_bad_is_single, m_tvalid && out_bad, !out_write && m_tlast, "bad op result")

	// The first beat of a pair writes memory and carries no idle count
	`WRUI_ASSERT_SAME(a_first_beat_writes, m_tvalid && !m_tlast, out_write && out_no_idle, "bad first beat")

	// The second beat follows its first beat without a gap
	`WRUI_ASSERT_NEXT(a_second_beat_follows, first_xfer, m_tvalid && m_tlast && out_write, "no second beat")

endmodule
